/* hw/rtl/keypad_code_lock_macros.svh */
// Assertion helpers for the keypad code lock.
// Each macro expects clk and arst_n to be visible in the module that uses it.
`ifndef KEYPAD_CODE_LOCK_MACROS_SVH
`define KEYPAD_CODE_LOCK_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define KCL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define KCL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/kcl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package kcl_pkg;

	localparam int CODE_DIGITS = 4;
	localparam int POS_W       = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

	localparam logic [9:0]  DEBOUNCE_LIMIT_RST = 10'd50;
	localparam logic [15:0] ENTRY_TIMEOUT_RST  = 16'd5000;
	localparam logic [15:0] ACCESS_CODE_RST    = 16'h2020;

	localparam logic [10:0] HELD_MAX  = 11'h7FF;
	localparam logic [15:0] SINCE_MAX = 16'hFFFF;
	localparam logic [3:0]  LAST_DIGIT_KEY = 4'd9;

	localparam logic [6:0] GLYPH_A   = 7'h77;
	localparam logic [6:0] GLYPH_F   = 7'h47;
	localparam logic [6:0] SEG_MASK  = 7'h7F;

	localparam logic [1:0] VERDICT_NONE     = 2'd0;
	localparam logic [1:0] VERDICT_MATCH    = 2'd1;
	localparam logic [1:0] VERDICT_MISMATCH = 2'd2;

	localparam logic [1:0] REG_DEBOUNCE_LIMIT = 2'd0;
	localparam logic [1:0] REG_ENTRY_TIMEOUT  = 2'd1;
	localparam logic [1:0] REG_ACCESS_CODE    = 2'd2;
	localparam logic [1:0] REG_COMMON_CATHODE = 2'd3;

	typedef struct packed {
		logic       key_down;
		logic [3:0] key_code;
	} kcl_in_t;

	typedef struct packed {
		logic       unlocked;
		logic [6:0] segments;
		logic       key_accepted;
		logic [1:0] verdict;
	} kcl_out_t;

	// Debouncer to entry logic: a key that passed debouncing this item.
	typedef struct packed {
		logic       accept;
		logic [3:0] key;
	} kcl_press_t;

	// Lit-segment pattern for a decimal digit; keys above nine light nothing.
	function automatic logic [6:0] digit_glyph(input logic [3:0] d);
		logic [6:0] g;
		case (d)
			4'd0: g = 7'h7E;
			4'd1: g = 7'h30;
			4'd2: g = 7'h6D;
			4'd3: g = 7'h79;
			4'd4: g = 7'h33;
			4'd5: g = 7'h5B;
			4'd6: g = 7'h5F;
			4'd7: g = 7'h70;
			4'd8: g = 7'h7F;
			4'd9: g = 7'h73;
			default: g = 7'h00;
		endcase
		return g;
	endfunction

	// Code digit for an entry slot; slots beyond the 16-bit code read as zero.
	function automatic logic [3:0] code_digit(input logic [15:0] code, input int pos);
		int shift;
		shift = 4 * (CODE_DIGITS - 1 - pos);
		if (shift >= 16 || shift < 0)
			return 4'd0;
		return 4'(code >> shift);
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/kcl_debounce.sv */
`timescale 1ns / 1ps
`default_nettype none

module kcl_debounce (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire kcl_pkg::kcl_in_t scan,
	input  wire logic [9:0]       limit,
	output kcl_pkg::kcl_press_t   press
);
	import kcl_pkg::*;

	localparam logic [1:0] PH_WAIT     = 2'd0;
	localparam logic [1:0] PH_DETECT   = 2'd1;
	localparam logic [1:0] PH_RELEASED = 2'd2;

	logic [1:0]  phase_q, phase_d;
	logic [10:0] held_q, held_d;
	logic [3:0]  key_q, key_d;
	logic        accept;

	always_comb begin
		phase_d = PH_WAIT;
		held_d  = held_q;
		key_d   = key_q;
		accept  = 1'b0;
		unique case (phase_q)
			PH_DETECT: begin
				if (scan.key_down) begin
					phase_d = PH_DETECT;
					if (held_q != HELD_MAX)
						held_d = held_q + 11'd1;
				end else begin
					phase_d = (held_q > {1'b0, limit}) ? PH_RELEASED : PH_WAIT;
				end
			end
			PH_RELEASED: begin
				// The scan on this item is ignored.
				accept = 1'b1;
			end
			default: begin
				if (scan.key_down) begin
					key_d   = scan.key_code;
					held_d  = 11'd0;
					phase_d = PH_DETECT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			held_q  <= 11'd0;
			key_q   <= 4'd0;
		end else if (en) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			key_q   <= key_d;
		end
	end

	assign press.accept = accept;
	assign press.key    = key_q;

endmodule

`default_nettype wire

/* hw/rtl/keypad_code_lock.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// scan      in         scan_valid / scan_ready    kcl_in_t  (key_down, key_code)
// result    out        result_valid / result_ready kcl_out_t (unlocked, segments,
//                                                  key_accepted, verdict)
// config    in         wr_en                      wr_index, wr_data
//
// Every scan item yields one result item, registered at acceptance and valid in the next cycle.
// A new scan item is taken every cycle while the result register is empty or
// being drained, so the sustained rate is one item per clock.
// Reset clears the debouncer, the entry sequence, the lock and the display.
// A stalled result holds scan_ready low; nothing inside advances meanwhile.

module keypad_code_lock (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              scan_valid,
	output logic                   scan_ready,
	input  wire kcl_pkg::kcl_in_t  scan,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output kcl_pkg::kcl_out_t      result,
	input  wire logic              wr_en,
	input  wire logic [1:0]        wr_index,
	input  wire logic [15:0]       wr_data
);
	import kcl_pkg::*;

	`include "keypad_code_lock_macros.svh"

	// Configuration registers.
	logic [9:0]  limit_q;
	logic [15:0] timeout_q;
	logic [15:0] code_q;
	logic        cathode_q;

	// Entry and display state.
	logic [POS_W-1:0]           pos_q;
	logic [CODE_DIGITS-1:0][3:0] keys_q;
	logic [15:0]                since_q;
	logic                       open_q;
	logic [6:0]                 latch_q;

	// Registered result.
	logic     res_valid_q;
	kcl_out_t res_q;

	logic       take;
	kcl_press_t press;

	logic [POS_W-1:0]            pos_eff, pos_d;
	logic [CODE_DIGITS-1:0][3:0] keys_d;
	logic [15:0]                 since_inc, since_d;
	logic                        open_d;
	logic [6:0]                  latch_d;
	logic [1:0]                  verdict_d;
	logic                        last, match;
	kcl_out_t                    res_d;

	// The result register frees up in the same cycle it is drained.
	assign scan_ready = !res_valid_q || result_ready;
	assign take       = scan_valid && scan_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= DEBOUNCE_LIMIT_RST;
			timeout_q <= ENTRY_TIMEOUT_RST;
			code_q    <= ACCESS_CODE_RST;
			cathode_q <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DEBOUNCE_LIMIT: limit_q   <= wr_data[9:0];
				REG_ENTRY_TIMEOUT:  timeout_q <= wr_data;
				REG_ACCESS_CODE:    code_q    <= wr_data;
				REG_COMMON_CATHODE: cathode_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	kcl_debounce u_debounce (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (take),
		.scan   (scan),
		.limit  (limit_q),
		.press  (press)
	);

	// Entry sequence: store the accepted key, restart on timeout, judge the
	// entry when its last digit arrives.
	always_comb begin
		since_inc = (since_q == SINCE_MAX) ? since_q : since_q + 16'd1;
		since_d   = since_inc;
		pos_eff   = pos_q;
		pos_d     = pos_q;
		keys_d    = keys_q;
		open_d    = open_q;
		latch_d   = latch_q;
		verdict_d = VERDICT_NONE;
		last      = 1'b0;
		match     = 1'b1;

		if (press.accept) begin
			// A stale partial entry starts over with this key.
			if (pos_q != '0 && since_inc >= timeout_q)
				pos_eff = '0;
			keys_d[pos_eff] = press.key;
			// Star and hash leave the display as it was.
			if (press.key <= LAST_DIGIT_KEY)
				latch_d = digit_glyph(press.key);
			since_d = 16'd0;
			last    = (pos_eff == POS_W'(CODE_DIGITS - 1));
			for (int i = 0; i < CODE_DIGITS; i++) begin
				if (keys_d[i] > LAST_DIGIT_KEY || keys_d[i] != code_digit(code_q, i))
					match = 1'b0;
			end
			if (last) begin
				pos_d = '0;
				if (match) begin
					open_d    = 1'b1;
					latch_d   = GLYPH_A;
					verdict_d = VERDICT_MATCH;
				end else begin
					open_d    = 1'b0;
					latch_d   = GLYPH_F;
					verdict_d = VERDICT_MISMATCH;
				end
			end else begin
				pos_d = pos_eff + POS_W'(1);
			end
		end

		res_d.unlocked     = open_d;
		res_d.segments     = cathode_q ? latch_d : (latch_d ^ SEG_MASK);
		res_d.key_accepted = press.accept;
		res_d.verdict      = verdict_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			keys_q  <= '0;
			since_q <= 16'd0;
			open_q  <= 1'b0;
			latch_q <= 7'd0;
		end else if (take) begin
			pos_q   <= pos_d;
			keys_q  <= keys_d;
			since_q <= since_d;
			open_q  <= open_d;
			latch_q <= latch_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// A verdict only comes with the key that completed the entry.
	`KCL_ASSERT_IMP(a_verdict_key, result_valid && result.verdict != VERDICT_NONE, result.key_accepted, "verdict without accepted key")
	// A match always leaves the lock open, a mismatch always closes it.
	`KCL_ASSERT_IMP(a_match_open, result_valid && result.verdict == VERDICT_MATCH, result.unlocked, "match left lock closed")
	`KCL_ASSERT_IMP(a_miss_closed, result_valid && result.verdict == VERDICT_MISMATCH, !result.unlocked, "mismatch left lock open")
	// No new scan is taken while a result waits to be drained.
	`KCL_ASSERT_IMP(a_stall_blocks, result_valid && !result_ready, !scan_ready, "scan taken over a stalled result")
	// An accepted scan always produces a result on the next cycle.
	`KCL_ASSERT_NEXT(a_take_result, take, result_valid, "accepted scan produced no result")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

// Testbench for the keypad code lock.
//
// Every scan item that the block takes is fed, at the same clock edge, into a
// cycle-accurate model of the lock kept in the scoreboard below. The model
// works out the one result item that the scan causes and queues it. Every
// result item that leaves the block is compared field by field with the
// oldest queued item.
//
// The run has a short hand-written part (star, hash, codes above eleven, a
// press too short to count, a press landing on the accept tick, a key that
// changes while held). After it come phases of random key entries under
// different register settings. Most random entries type the current code
// digit, so that whole entries reach the compare, open the lock and get
// refused.

module tb_top;
	import kcl_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	// Debouncer phases of the model.
	typedef enum logic [1:0] {
		DB_WAIT,
		DB_HELD,
		DB_RELEASED
	} db_phase_e;

	// How the two sides of the block idle during a phase.
	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idling_e;

	// The scoreboard keeps its own copy of the lock's registers and state.
	// take_scan advances the copy by one scan item and queues the result item
	// that the block must produce; check_output compares one result item.
	class lock_scoreboard;
		logic [9:0]  debounce_limit;
		logic [15:0] entry_timeout;
		logic [15:0] access_code;
		logic        common_cathode;

		db_phase_e   phase;
		logic [10:0] held_ticks;
		logic [3:0]  held_key;
		int          entry_pos;
		logic [3:0]  entered [CODE_DIGITS];
		logic [15:0] since_digit;
		logic        lock_open;
		logic [6:0]  lit;
		logic [6:0]  glyph [10];

		kcl_out_t    lock_outputs_due [$];
		int          faults;
		int          results_checked;
		int          keys_taken;
		int          opened;
		int          refused;

		function new();
			debounce_limit = DEBOUNCE_LIMIT_RST;
			entry_timeout = ENTRY_TIMEOUT_RST;
			access_code = ACCESS_CODE_RST;
			common_cathode = 1'b0;
			phase = DB_WAIT;
			held_ticks = '0;
			held_key = '0;
			entry_pos = 0;
			foreach (entered[i])
				entered[i] = '0;
			since_digit = '0;
			lock_open = 1'b0;
			lit = '0;
			glyph = '{7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h73};
			faults = 0;
			results_checked = 0;
			keys_taken = 0;
			opened = 0;
			refused = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] data);
			case (idx)
				REG_DEBOUNCE_LIMIT: debounce_limit = data[9:0];
				REG_ENTRY_TIMEOUT:  entry_timeout = data;
				REG_ACCESS_CODE:    access_code = data;
				REG_COMMON_CATHODE: common_cathode = data[0];
				default: ;
			endcase
		endfunction

		// Code digit for an entry slot, first digit in the top nibble.
		function logic [3:0] code_nibble(int pos);
			int shift;
			shift = 4 * (CODE_DIGITS - 1 - pos);
			if (shift >= 16)
				return 4'd0;
			return access_code[shift +: 4];
		endfunction

		// The digit that would continue a correct entry from here.
		function logic [3:0] wanted_key();
			return code_nibble(entry_pos);
		endfunction

		function void take_scan(kcl_in_t s);
			logic       accept;
			logic       opens;
			logic [1:0] verdict;
			kcl_out_t   want;
			accept = 1'b0;
			verdict = VERDICT_NONE;
			if (since_digit != SINCE_MAX)
				since_digit++;
			case (phase)
				DB_HELD: begin
					if (s.key_down) begin
						if (held_ticks != HELD_MAX)
							held_ticks++;
					end else begin
						phase = (held_ticks > {1'b0, debounce_limit}) ? DB_RELEASED : DB_WAIT;
					end
				end
				DB_RELEASED: begin
					// The scan on the accept tick is ignored.
					accept = 1'b1;
					phase = DB_WAIT;
				end
				default: begin
					phase = DB_WAIT;
					if (s.key_down) begin
						held_key = s.key_code;
						held_ticks = '0;
						phase = DB_HELD;
					end
				end
			endcase
			if (accept) begin
				keys_taken++;
				if (entry_pos != 0 && since_digit >= entry_timeout)
					entry_pos = 0;
				entered[entry_pos] = held_key;
				// Star, hash and the codes above them keep the display as it is.
				if (held_key <= LAST_DIGIT_KEY)
					lit = glyph[held_key];
				since_digit = '0;
				if (entry_pos + 1 >= CODE_DIGITS) begin
					opens = 1'b1;
					for (int k = 0; k < CODE_DIGITS; k++) begin
						if (entered[k] > LAST_DIGIT_KEY || entered[k] != code_nibble(k))
							opens = 1'b0;
					end
					lock_open = opens;
					lit = opens ? GLYPH_A : GLYPH_F;
					verdict = opens ? VERDICT_MATCH : VERDICT_MISMATCH;
					if (opens)
						opened++;
					else
						refused++;
					entry_pos = 0;
				end else begin
					entry_pos++;
				end
			end
			want.unlocked = lock_open;
			want.segments = common_cathode ? lit : ~lit;
			want.key_accepted = accept;
			want.verdict = verdict;
			lock_outputs_due.push_back(want);
		endfunction

		function string show(kcl_out_t r);
			return $sformatf("unlocked=%0b segments=%02h accepted=%0b verdict=%0d",
				r.unlocked, r.segments, r.key_accepted, r.verdict);
		endfunction

		function void check_output(kcl_out_t got);
			kcl_out_t want;
			if (lock_outputs_due.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("tb_top: result with nothing expected: %s", show(got));
				return;
			end
			want = lock_outputs_due.pop_front();
			results_checked++;
			if (got.unlocked !== want.unlocked || got.segments !== want.segments ||
					got.key_accepted !== want.key_accepted || got.verdict !== want.verdict) begin
				faults++;
				if (faults <= 10)
					$display("tb_top: result %0d mismatch: expected %s, got %s",
						results_checked, show(want), show(got));
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        scan_valid = 1'b0;
	logic        scan_ready;
	kcl_in_t     scan = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	kcl_out_t    result;
	logic        wr_en = 1'b0;
	logic [1:0]  wr_index = REG_DEBOUNCE_LIMIT;
	logic [15:0] wr_data = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int scans_sent = 0;
	int cycle_count = 0;

	lock_scoreboard sb;

	keypad_code_lock i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.scan_valid   (scan_valid),
		.scan_ready   (scan_ready),
		.scan         (scan),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The receiver decides at each falling edge whether it takes a result in
	// the coming cycle.
	always @(negedge clk) begin
		result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Results are sampled at the rising edge that moves them.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_output(result);
	end

	// A hung block must not hang the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: cycle limit reached with %0d results still due",
				sb.lock_outputs_due.size());
			$display("tb_top: done, errors");
			$finish;
		end
	end

	task automatic set_idling(input idling_e mode);
		case (mode)
			IDLE_SENDER: begin
				send_idle_pct = 59;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				recv_stall_pct = 59;
			end
			IDLE_BOTH: begin
				send_idle_pct = 38;
				recv_stall_pct = 38;
			end
			default: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	// Offers one scan item from a falling edge on and returns at the rising
	// edge that takes it. Valid stays high on return; the next call either
	// replaces the payload or drops valid, never both in one step.
	task automatic send_scan(input kcl_in_t s);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			scan_valid <= 1'b0;
			@(negedge clk);
		end
		scan <= s;
		scan_valid <= 1'b1;
		@(posedge clk);
		while (!scan_ready)
			@(posedge clk);
		sb.take_scan(s);
		scans_sent++;
	endtask

	// Drops valid after the last item of a stretch, so that it is not taken twice.
	task automatic stop_scan();
		@(negedge clk);
		scan_valid <= 1'b0;
	endtask

	// One key press: the press tick, the held ticks (now and then with another
	// code, which the debouncer must ignore), then the release and more idle ticks.
	task automatic tap(input logic [3:0] key, input int held, input int gap);
		kcl_in_t s;
		s.key_down = 1'b1;
		s.key_code = key;
		send_scan(s);
		for (int i = 0; i < held; i++) begin
			s.key_down = 1'b1;
			s.key_code = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15)) : key;
			send_scan(s);
		end
		for (int i = 0; i <= gap; i++) begin
			s.key_down = 1'b0;
			s.key_code = 4'($urandom_range(0, 15));
			send_scan(s);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		sb.set_reg(idx, data);
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// Waits until every result has left the block, then writes all four
	// registers. Unused upper bits of the narrow registers carry noise.
	task automatic program_lock(input logic [9:0] lim, input logic [15:0] tmo,
			input logic [15:0] code, input logic cc);
		while (sb.lock_outputs_due.size() != 0)
			@(posedge clk);
		write_reg(REG_DEBOUNCE_LIMIT, {6'($urandom), lim});
		write_reg(REG_ENTRY_TIMEOUT, tmo);
		write_reg(REG_ACCESS_CODE, code);
		write_reg(REG_COMMON_CATHODE, {15'($urandom), cc});
	endtask

	// Random key entries. Most presses type the digit that continues a correct
	// entry and are held close to the debounce limit; the rest are other keys
	// or single noise scans.
	task automatic enter_codes(input int n_items, input int gap_max);
		int         stop_at;
		int         lim;
		int         hold;
		logic [3:0] key;
		kcl_in_t    s;
		stop_at = scans_sent + n_items;
		lim = sb.debounce_limit;
		while (scans_sent < stop_at) begin
			if ($urandom_range(0, 9) == 0) begin
				s.key_down = 1'($urandom_range(0, 1));
				s.key_code = 4'($urandom_range(0, 15));
				send_scan(s);
			end else begin
				if ($urandom_range(0, 9) < 7)
					key = sb.wanted_key();
				else if ($urandom_range(0, 3) == 0)
					key = 4'($urandom_range(0, 15));
				else
					key = 4'($urandom_range(0, 11));
				hold = (lim > 2) ? lim - 2 + $urandom_range(0, 5) : $urandom_range(0, lim + 3);
				tap(key, hold, $urandom_range(0, gap_max));
			end
		end
		stop_scan();
	endtask

	function automatic logic [15:0] random_code();
		return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
			4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
	endfunction

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Hand-written part. A star press too short for the reset debounce
		// limit shows the reset state of the lock and the display.
		set_idling(IDLE_NONE);
		tap(4'd11, 0, 0);
		stop_scan();
		// With a zero limit one held tick is enough. The code holds a digit
		// that no key can match. The press after a zero gap lands on the
		// accept tick and is lost; the others cover a too-short press, star,
		// hash and a code above eleven.
		program_lock(10'd0, 16'hFFFF, 16'h90A0, 1'b1);
		tap(4'd9, 1, 1);
		tap(4'd0, 0, 1);
		tap(4'd15, 1, 0);
		tap(4'd10, 2, 1);
		tap(4'd11, 1, 1);
		tap(4'd0, 1, 1);
		stop_scan();

		// A zero timeout restarts the entry at every key.
		set_idling(IDLE_SENDER);
		program_lock(10'd0, 16'd0, 16'h1234, 1'b1);
		enter_codes(100, 3);

		// A short timeout against gaps that sometimes exceed it.
		set_idling(IDLE_RECEIVER);
		program_lock(10'd2, 16'd12, 16'h7305, 1'b0);
		enter_codes(180, 15);

		// The values that reset loads.
		set_idling(IDLE_BOTH);
		program_lock(DEBOUNCE_LIMIT_RST, ENTRY_TIMEOUT_RST, ACCESS_CODE_RST, 1'b0);
		enter_codes(240, 4);

		// Code digits of fifteen: every entry is refused.
		set_idling(IDLE_NONE);
		program_lock(10'd1, 16'hFFFF, 16'hFFFF, 1'b1);
		enter_codes(130, 3);

		set_idling(IDLE_SENDER);
		program_lock(10'd3, 16'd1, 16'h0000, 1'b0);
		enter_codes(100, 2);

		set_idling(IDLE_BOTH);
		program_lock(10'($urandom_range(0, 6)), 16'($urandom_range(4, 40)), random_code(),
			1'($urandom_range(0, 1)));
		enter_codes(240, 12);

		set_idling(IDLE_NONE);
		program_lock(10'($urandom_range(0, 6)), 16'($urandom_range(4, 40)), random_code(),
			1'($urandom_range(0, 1)));
		enter_codes(110, 8);

		// Let the last results out, then give the block a few more cycles in
		// which nothing may appear.
		while (sb.lock_outputs_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("tb_top: %0d scan items under eight register settings, %0d results checked",
			scans_sent, sb.results_checked);
		$display("tb_top: %0d keys entered, %0d entries opened the lock, %0d refused",
			sb.keys_taken, sb.opened, sb.refused);
		if (sb.faults == 0 && sb.lock_outputs_due.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/kcl_pkg.sv
hw/rtl/kcl_debounce.sv
hw/rtl/keypad_code_lock.sv
tb/tb_top.sv
